[rtl/assert_macros.svh]
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

[rtl/clq_pkg.sv]
// Package with the item kinds, field widths and shared types of the rank query core.
`default_nettype none

package clq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;
    localparam int KIND_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2
    } clq_kind_t;

    // Query token that walks down the cell row.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] key;
    } clq_tok_t;

    // One result item.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               status;
    } clq_res_t;

    // Occupancy flags of the result queue.
    typedef struct packed {
        logic empty;
        logic full;
    } clq_q_stat_t;

endpackage

`default_nettype wire

[rtl/clq_cell.sv]
// One cell of the row: holds a stored value and counts it against a passing query key.
`default_nettype none

module clq_cell
    import clq_pkg::*;
#(
    parameter int CNT_W    = 8,
    parameter int CELL_IDX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CNT_W-1:0]          fill,
    input  logic                      shift_en,
    input  logic signed [VALUE_W-1:0] shift_in,
    output logic signed [VALUE_W-1:0] val_out,
    input  clq_tok_t                  tok_in,
    input  logic [CNT_W-1:0]          acc_in,
    output clq_tok_t                  tok_out,
    output logic [CNT_W-1:0]          acc_out
);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic                      tok_valid_reg;
    logic [CNT_W-1:0]          acc_reg;
    logic [CNT_W-1:0]          acc_next;
    logic                      hit;

    // The cell holds a live value only when its position lies below the fill count.
    assign hit      = tok_in.valid && (fill > CNT_W'(CELL_IDX)) && (val_reg <= tok_in.key);
    assign acc_next = acc_in + CNT_W'(hit);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            val_reg <= shift_in;
        end
        key_reg <= tok_in.key;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    assign val_out       = val_reg;
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.key   = key_reg;
    assign acc_out       = acc_reg;

endmodule

`default_nettype wire

[rtl/clq_out_q.sv]
// Two-entry result queue that lets the input side run while a result waits.
`default_nettype none

module clq_out_q
    import clq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  clq_res_t    wr_data,
    input  logic        rd_en,
    output clq_res_t    rd_data,
    output clq_q_stat_t stat
);

    clq_res_t   q_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign rd_data    = q_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == 2'd0);
    assign stat.full  = (cnt_reg == 2'd2);

endmodule

`default_nettype wire

[rtl/count_less_or_equal_query_core.sv]
// Top level of the rank query core: counts stored values less than or equal to a key.
// A clear, load or unused-kind transfer writes its result into the result queue as it is accepted;
// a query's result is written once its key has walked the registered cell row.
// Throughput: one item in flight; non-query items at one per cycle while the result queue has room,
// and a query holds the input side closed while its token passes every cell.
// Reset clears the fill count, the query row and the result queue; stored values stay undefined.
`default_nettype none

`include "assert_macros.svh"

module count_less_or_equal_query_core
    import clq_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [COUNT_W-1:0]     m_axis_tdata,   // [7:0] count
    output logic                   m_axis_tuser    // [0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Narrows or widens a fill count to the eight-bit result field.
    function automatic logic [COUNT_W-1:0] fit_count(input logic [CNT_W-1:0] x);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, x};
        return wide[COUNT_W-1:0];
    endfunction

    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      in_xfer;
    logic                      out_xfer;
    logic                      shift_en;
    logic                      launch;
    logic                      res_wr;
    clq_res_t                  res;
    clq_res_t                  q_head;
    clq_q_stat_t               q_stat;
    clq_kind_t                 kind_in;

    // The cell row: element i feeds cell i, element i + 1 is what cell i hands on.
    clq_tok_t                  tok_chain [0:CAPACITY];
    logic [CNT_W-1:0]          acc_chain [0:CAPACITY];
    logic signed [VALUE_W-1:0] val_chain [0:CAPACITY];

    assign kind_in  = clq_kind_t'(s_axis_tuser);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Only one item is in flight, and the queue keeps a free slot for its result.
    assign s_axis_tready = !busy_reg && !q_stat.full;

    // Decode of the accepted item and collection of the finished query.
    always_comb
    begin
        fill_next    = fill_reg;
        shift_en     = 1'b0;
        launch       = 1'b0;
        res_wr       = 1'b0;
        res.status   = 1'b0;
        if (in_xfer)
        begin
            unique case (kind_in)
                KIND_CLEAR:
                begin
                    fill_next = '0;
                    res_wr    = 1'b1;
                end
                KIND_LOAD:
                begin
                    // A load into a full set is dropped and flagged.
                    if (fill_reg < CNT_W'(CAPACITY))
                    begin
                        shift_en  = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res.status = 1'b1;
                    end
                    res_wr = 1'b1;
                end
                KIND_QUERY:
                begin
                    launch = 1'b1;
                end
                default:
                begin
                    res_wr = 1'b1;
                end
            endcase
        end
        res.count = fit_count(fill_next);
        // The query token leaving the last cell carries the finished count.
        if (tok_chain[CAPACITY].valid)
        begin
            res_wr     = 1'b1;
            res.status = 1'b0;
            res.count  = fit_count(acc_chain[CAPACITY]);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (launch)
        begin
            busy_next = 1'b1;
        end
        else if (tok_chain[CAPACITY].valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

    // A load shifts the row by one place, so live values always sit in the lowest cells.
    assign val_chain[0]       = s_axis_tdata;
    assign tok_chain[0].valid = launch;
    assign tok_chain[0].key   = s_axis_tdata;
    assign acc_chain[0]       = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        clq_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .fill     (fill_reg),
            .shift_en (shift_en),
            .shift_in (val_chain[gi]),
            .val_out  (val_chain[gi+1]),
            .tok_in   (tok_chain[gi]),
            .acc_in   (acc_chain[gi]),
            .tok_out  (tok_chain[gi+1]),
            .acc_out  (acc_chain[gi+1])
        );
    end

    clq_out_q u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res),
        .rd_en   (out_xfer),
        .rd_data (q_head),
        .stat    (q_stat)
    );

    assign m_axis_tvalid = !q_stat.empty;
    assign m_axis_tdata  = q_head.count;
    assign m_axis_tuser  = q_head.status;

    // The fill count never passes the capacity of the set.
    `ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CNT_W'(CAPACITY),
                "fill count exceeds capacity")

    // A query token only reaches the end of the row while a query is outstanding.
    `ASSERT_NOW(a_tail_busy, clk, rst_n, tok_chain[CAPACITY].valid, busy_reg,
                "query result without an outstanding query")

    // A result is never written into a full queue.
    `ASSERT_NOW(a_q_room, clk, rst_n, res_wr && q_stat.full, out_xfer,
                "result written into a full queue")

    // An accepted query keeps the input side closed on the next cycle.
    `ASSERT_NEXT(a_query_holds, clk, rst_n, launch, !s_axis_tready,
                 "input accepted while a query is in flight")

endmodule

`default_nettype wire

[tb/tb_count_less_or_equal_query_core.sv]
// Self-checking testbench for the rank query core: directed table, then random load/query runs.
`timescale 1ns / 100ps
`default_nettype none

module tb_count_less_or_equal_query_core
    import clq_pkg::*;
();

    localparam int CAPACITY     = 128;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 1750;
    localparam int CALM_ITEMS   = 150;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;

    // The unused kind code has no enum member; the block must treat it as a no-op.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata;   // [31:0] value
    logic [KIND_W-1:0]   s_axis_tuser;   // [1:0] kind
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [COUNT_W-1:0]  m_axis_tdata;   // [7:0] count
    logic                m_axis_tuser;   // [0] status

    count_less_or_equal_query_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the reference set, kept in load order.
    logic signed [VALUE_W-1:0] shadow_vals [CAPACITY];
    int unsigned               shadow_fill;

    clq_res_t pending_results [$];
    int       mismatch_count;
    int       items_sent;
    int       gap_pct;
    int       hold_request;
    bit       calm;

    // Directed rows; rows with typed set carry an expectation typed in by hand.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [COUNT_W-1:0] count;
        logic               status;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    dir_row_t dir_table [DIR_ROWS] = '{
        '{KIND_QUERY,  VAL_ZERO,     1'b1, 8'd0, 1'b0},   // query on the empty set
        '{KIND_UNUSED, 32'h1234_5678, 1'b1, 8'd0, 1'b0},  // unused kind is a no-op
        '{KIND_CLEAR,  VAL_ZERO,     1'b1, 8'd0, 1'b0},
        '{KIND_LOAD,   VAL_MAX,      1'b1, 8'd1, 1'b0},
        '{KIND_LOAD,   VAL_MIN,      1'b1, 8'd2, 1'b0},
        '{KIND_LOAD,   VAL_ZERO,     1'b1, 8'd3, 1'b0},
        '{KIND_LOAD,   VAL_NEG1,     1'b1, 8'd4, 1'b0},
        '{KIND_QUERY,  VAL_MIN,      1'b1, 8'd1, 1'b0},
        '{KIND_QUERY,  VAL_MAX,      1'b1, 8'd4, 1'b0},
        '{KIND_QUERY,  VAL_NEG1,     1'b1, 8'd2, 1'b0},
        '{KIND_QUERY,  VAL_ZERO,     1'b1, 8'd3, 1'b0},
        '{KIND_QUERY,  32'hFFFF_FFFE, 1'b1, 8'd1, 1'b0},
        '{KIND_UNUSED, VAL_NEG1,     1'b1, 8'd4, 1'b0},
        '{KIND_LOAD,   VAL_ZERO,     1'b1, 8'd5, 1'b0},  // duplicate value
        '{KIND_QUERY,  VAL_ZERO,     1'b1, 8'd4, 1'b0},
        '{KIND_QUERY,  32'h7FFF_FFFE, 1'b1, 8'd4, 1'b0},
        '{KIND_LOAD,   32'hA5A5_A5A5, 1'b0, 8'd0, 1'b0},
        '{KIND_QUERY,  32'h0000_0001, 1'b0, 8'd0, 1'b0},
        '{KIND_CLEAR,  VAL_NEG1,     1'b1, 8'd0, 1'b0},
        '{KIND_QUERY,  VAL_MAX,      1'b1, 8'd0, 1'b0},  // cleared set answers zero
        '{KIND_LOAD,   32'h5A5A_5A5A, 1'b1, 8'd1, 1'b0},
        '{KIND_QUERY,  32'h5A5A_5A59, 1'b1, 8'd0, 1'b0},
        '{KIND_QUERY,  32'h5A5A_5A5A, 1'b1, 8'd1, 1'b0},
        '{KIND_CLEAR,  VAL_ZERO,     1'b1, 8'd0, 1'b0}
    };

    // Applies one item to the shadow set and returns the result the block should give.
    function automatic clq_res_t rank_step(input logic [KIND_W-1:0] kind,
                                           input logic [VALUE_W-1:0] value);
        clq_res_t    res;
        int unsigned hits;
        res.status = 1'b0;
        res.count  = '0;
        case (kind)
            KIND_CLEAR:
            begin
                shadow_fill = 0;
            end
            KIND_LOAD:
            begin
                if (shadow_fill < CAPACITY)
                begin
                    shadow_vals[IDX_W'(shadow_fill)] = value;
                    shadow_fill++;
                end
                else
                begin
                    res.status = 1'b1;
                end
                res.count = COUNT_W'(shadow_fill);
            end
            KIND_QUERY:
            begin
                hits = 0;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_vals[IDX_W'(i)] <= $signed(value))
                        hits++;
                end
                res.count = COUNT_W'(hits);
            end
            default:
            begin
                res.count = COUNT_W'(shadow_fill);
            end
        endcase
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input bit narrow);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_ZERO;
                default: return VAL_NEG1;
            endcase
        end
        // Narrow values give many duplicates and ties around the query keys.
        if (narrow || r < 4)
            return VALUE_W'($signed($urandom_range(0, 31)) - 16);
        return $urandom;
    endfunction

    // Keys sit on or next to a stored value half the time, so that ties and off-by-one edges get hit.
    function automatic logic [VALUE_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && shadow_fill > 0)
            return shadow_vals[IDX_W'($urandom_range(0, shadow_fill - 1))]
                   + VALUE_W'($signed($urandom_range(0, 2)) - 1);
        return pick_value(r < 7);
    endfunction

    // Offers one transfer on the input side and books its expected result once accepted.
    task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                              input bit typed, input clq_res_t typed_res);
        clq_res_t predicted;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tuser  = kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = rank_step(kind, value);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        items_sent++;
        if (items_sent >= ITEM_TARGET - CALM_ITEMS)
            calm = 1'b1;
    endtask

    task automatic offer_random(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        offer_item(kind, value, 1'b0, '0);
    endtask

    // Drops valid and waits until every booked result has been seen.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stall bursts, one long hold on request, always ready once calm.
    initial
    begin
        int stall_left;
        int stall_pct;
        int window;
        stall_left    = 0;
        stall_pct     = 0;
        window        = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (window == 0)
            begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
                window = 64;
            end
            window--;
            if (hold_request > 0)
            begin
                m_axis_tready = 1'b0;
                hold_request--;
            end
            else if (calm)
            begin
                m_axis_tready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(1, 10) - 1;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Result checker: each output transfer is matched against the oldest booked result.
    initial
    begin
        clq_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: count=%0d status=%0d",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.count || m_axis_tuser !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected count=%0d status=%0d, %s%0d %s%0d",
                                     want.count, want.status, "got count=", m_axis_tdata,
                                     "status=", m_axis_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        clq_res_t    typed_res;
        int          episode;
        int          n;
        int          nl;
        int          nq;
        bit          narrow;
        bit          drained_mid;
        bit          held;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        shadow_fill    = 0;
        mismatch_count = 0;
        items_sent     = 0;
        gap_pct        = 20;
        hold_request   = 0;
        calm           = 1'b0;
        episode        = 0;
        drained_mid    = 1'b0;
        held           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            typed_res.count  = dir_table[i].count;
            typed_res.status = dir_table[i].status;
            offer_item(dir_table[i].kind, dir_table[i].value, dir_table[i].typed, typed_res);
        end
        // The sender stays quiet until the block has answered everything.
        drain_results();

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase

            if (!held && episode > 0)
            begin
                // Long hold on the output while the sender keeps offering.
                hold_request = LONG_HOLD;
                held = 1'b1;
            end

            if (episode == 0 || $urandom_range(0, 9) < 2)
            begin
                // Fill past capacity so that loads into a full set get dropped.
                offer_random(KIND_CLEAR, pick_value(1'b0));
                n = CAPACITY + $urandom_range(1, 6);
                narrow = $urandom_range(0, 1);
                for (int i = 0; i < n; i++)
                begin
                    offer_random(KIND_LOAD, pick_value(narrow));
                    if ($urandom_range(0, 7) == 0)
                        offer_random(KIND_QUERY, pick_key());
                end
                repeat (3) offer_random(KIND_QUERY, pick_key());
                offer_random(KIND_UNUSED, pick_value(1'b0));
            end
            else if ($urandom_range(0, 9) < 8)
            begin
                // Short runs of loads and queries, mostly on a freshly cleared set.
                if ($urandom_range(0, 3) != 0)
                    offer_random(KIND_CLEAR, pick_value(1'b0));
                nl = $urandom_range(1, 20);
                nq = $urandom_range(1, 12);
                narrow = ($urandom_range(0, 2) != 0);
                while (nl + nq > 0)
                begin
                    if (nq == 0 || (nl > 0 && $urandom_range(0, 1) == 0))
                    begin
                        offer_random(KIND_LOAD, pick_value(narrow));
                        nl--;
                    end
                    else
                    begin
                        offer_random(KIND_QUERY, pick_key());
                        nq--;
                    end
                end
            end
            else
            begin
                // Noise: any kind, including the unused code.
                n = $urandom_range(5, 20);
                for (int i = 0; i < n; i++)
                    offer_random(KIND_W'($urandom_range(0, 3)), pick_value(1'b0));
            end

            if (!drained_mid && items_sent > ITEM_TARGET / 2)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
            episode++;
        end

        drain_results();
        // The wait outlasts a query's walk through the cell row, so a stray result would show up.
        repeat (CAPACITY + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
